// File: rtl/rhid_pkg.sv
`timescale 1ns / 1ps
package rhid_pkg;

	localparam logic [7:0]  MAGIC_BYTE     = 8'h24;
	localparam logic [7:0]  VIDEO_CHAN_RST = 8'h02;
	localparam logic [15:0] RTP_HDR_LEN    = 16'd12;
	localparam logic [15:0] MIN_BODY_LEN   = 16'd13;
	localparam logic [15:0] FU_HDR_END     = 16'd14;

	// parse phases
	localparam logic [2:0] PH_MAGIC  = 3'd0;
	localparam logic [2:0] PH_CHAN   = 3'd1;
	localparam logic [2:0] PH_LEN_HI = 3'd2;
	localparam logic [2:0] PH_LEN_LO = 3'd3;
	localparam logic [2:0] PH_BODY   = 3'd4;

	// frame kinds
	localparam logic [2:0] KIND_OTHER = 3'd0;
	localparam logic [2:0] KIND_T1    = 3'd1;
	localparam logic [2:0] KIND_T5    = 3'd2;
	localparam logic [2:0] KIND_T6    = 3'd3;
	localparam logic [2:0] KIND_T7    = 3'd4;
	localparam logic [2:0] KIND_T8    = 3'd5;

	localparam logic [7:0] SC_ZERO = 8'h00;
	localparam logic [7:0] SC_LAST = 8'h01;
	localparam logic [2:0] SC_LEN  = 3'd4;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;
	localparam int QCNT_W      = 3;

	typedef struct packed {
		logic       start_code;
		logic [7:0] data;
		logic       frame_end;
		logic [2:0] kind;
	} cmd_t;

	function automatic logic [2:0] nal_kind(input logic [7:0] b);
		logic [2:0] k;
		case (b[4:0])
			5'd1:    k = KIND_T1;
			5'd5:    k = KIND_T5;
			5'd6:    k = KIND_T6;
			5'd7:    k = KIND_T7;
			5'd8:    k = KIND_T8;
			default: k = KIND_OTHER;
		endcase
		return k;
	endfunction

endpackage

// File: rtl/rhid_front.sv
`timescale 1ns / 1ps
module rhid_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         data_byte,
	input  logic [7:0]         video_channel,
	input  logic               q_full,
	output logic               push,
	output rhid_pkg::cmd_t     push_cmd
);

	logic [2:0]  phase_q;
	logic [15:0] pos_q;
	logic [15:0] len_q;
	logic        chan_match_q;
	logic        marker_q;
	logic        cont_q;
	logic [7:0]  fi_q;
	logic [2:0]  kind_q;

	logic        fire;
	logic        body_ok;
	logic        last;
	logic        in_payload;
	logic        p0;
	logic        p1;
	logic        emit;
	logic        sc;
	logic [7:0]  odata;
	logic [2:0]  kind_nxt;
	logic [15:0] len_full;

	assign in_ready = !q_full;
	assign fire     = in_valid && in_ready;
	assign len_full = {len_q[15:8], data_byte};

	always_comb begin
		body_ok    = chan_match_q && (len_q >= rhid_pkg::MIN_BODY_LEN);
		last       = ({1'b0, pos_q} + 17'd1) >= {1'b0, len_q};
		in_payload = pos_q >= rhid_pkg::RTP_HDR_LEN;
		p0         = pos_q == rhid_pkg::RTP_HDR_LEN;
		p1         = pos_q == rhid_pkg::MIN_BODY_LEN;
		emit       = 1'b0;
		sc         = 1'b0;
		odata      = data_byte;
		kind_nxt   = kind_q;
		if (phase_q == rhid_pkg::PH_BODY && body_ok && in_payload) begin
			if (!cont_q) begin
				if (marker_q) begin
					emit = 1'b1;
					sc   = p0;
					if (p0)
						kind_nxt = rhid_pkg::nal_kind(data_byte);
				end else if (p0) begin
					kind_nxt = rhid_pkg::KIND_OTHER;
				end else if (p1) begin
					// rebuild NAL header from F/NRI and the fragment type
					kind_nxt = rhid_pkg::nal_kind(data_byte);
					emit     = 1'b1;
					sc       = 1'b1;
					odata    = {fi_q[7:5], data_byte[4:0]};
				end else begin
					emit = 1'b1;
				end
			end else if (pos_q >= rhid_pkg::FU_HDR_END) begin
				emit = 1'b1;
			end
		end
	end

	assign push                = fire && emit;
	assign push_cmd.start_code = sc;
	assign push_cmd.data       = odata;
	assign push_cmd.frame_end  = last && marker_q;
	assign push_cmd.kind       = (last && marker_q) ? kind_nxt : rhid_pkg::KIND_OTHER;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= rhid_pkg::PH_MAGIC;
			pos_q        <= '0;
			len_q        <= '0;
			chan_match_q <= 1'b0;
			marker_q     <= 1'b0;
			cont_q       <= 1'b0;
			fi_q         <= '0;
			kind_q       <= rhid_pkg::KIND_OTHER;
		end else if (fire) begin
			case (phase_q)
				rhid_pkg::PH_MAGIC: begin
					if (data_byte == rhid_pkg::MAGIC_BYTE)
						phase_q <= rhid_pkg::PH_CHAN;
				end
				rhid_pkg::PH_CHAN: begin
					chan_match_q <= data_byte == video_channel;
					phase_q      <= rhid_pkg::PH_LEN_HI;
				end
				rhid_pkg::PH_LEN_HI: begin
					len_q   <= {data_byte, 8'h00};
					phase_q <= rhid_pkg::PH_LEN_LO;
				end
				rhid_pkg::PH_LEN_LO: begin
					len_q   <= len_full;
					pos_q   <= '0;
					phase_q <= (len_full == '0) ? rhid_pkg::PH_MAGIC : rhid_pkg::PH_BODY;
				end
				rhid_pkg::PH_BODY: begin
					if (pos_q == 16'd1)
						marker_q <= data_byte[7];
					if (body_ok && in_payload && !cont_q && !marker_q && p0)
						fi_q <= data_byte;
					kind_q <= kind_nxt;
					if (last) begin
						if (body_ok)
							cont_q <= !marker_q;
						phase_q <= rhid_pkg::PH_MAGIC;
						pos_q   <= '0;
					end else begin
						pos_q <= pos_q + 16'd1;
					end
				end
				default: phase_q <= rhid_pkg::PH_MAGIC;
			endcase
		end
	end

endmodule

// File: rtl/rhid_queue.sv
`timescale 1ns / 1ps
module rhid_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  rhid_pkg::cmd_t        push_cmd,
	input  logic                  pop,
	output logic                  full,
	output logic                  empty,
	output rhid_pkg::cmd_t        head
);

	rhid_pkg::cmd_t                 mem_q [rhid_pkg::QUEUE_DEPTH];
	logic [rhid_pkg::QPTR_W-1:0]    wr_ptr_q;
	logic [rhid_pkg::QPTR_W-1:0]    rd_ptr_q;
	logic [rhid_pkg::QCNT_W-1:0]    cnt_q;

	assign full  = cnt_q == rhid_pkg::QCNT_W'(rhid_pkg::QUEUE_DEPTH);
	assign empty = cnt_q == '0;
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop))
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("queue read while empty");

endmodule

// File: rtl/rhid_back.sv
`timescale 1ns / 1ps
module rhid_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               empty,
	input  rhid_pkg::cmd_t     head,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [7:0]         out_byte,
	output logic               frame_end,
	output logic [2:0]         frame_kind
);

	logic [2:0] sc_q;
	logic       out_valid_q;
	logic [7:0] byte_q;
	logic       end_q;
	logic [2:0] kind_q;
	logic       load;
	logic       in_sc;

	assign load  = !empty && (!out_valid_q || out_ready);
	assign in_sc = head.start_code && (sc_q != rhid_pkg::SC_LEN);
	assign pop   = load && !in_sc;

	assign out_valid  = out_valid_q;
	assign out_byte   = byte_q;
	assign frame_end  = end_q;
	assign frame_kind = kind_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sc_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			if (load)
				sc_q <= in_sc ? sc_q + 3'd1 : 3'd0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (in_sc) begin
				byte_q <= (sc_q == rhid_pkg::SC_LEN - 3'd1) ? rhid_pkg::SC_LAST
				                                            : rhid_pkg::SC_ZERO;
				end_q  <= 1'b0;
				kind_q <= rhid_pkg::KIND_OTHER;
			end else begin
				byte_q <= head.data;
				end_q  <= head.frame_end;
				kind_q <= head.kind;
			end
		end
	end

	a_sc_done: assert property (@(posedge clk) disable iff (!arst_n)
		(load && !in_sc) |=> sc_q == 3'd0)
		else $error("start code counter not cleared after data word");

	a_kind_on_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (end_q || kind_q == rhid_pkg::KIND_OTHER))
		else $error("frame kind set on a word that does not end the frame");

endmodule

// File: rtl/rtp_h264_interleaved_depacketizer.sv
`timescale 1ns / 1ps
// Channel  Handshake              Payload
// input    in_valid / in_ready    data_byte[7:0]
// output   out_valid / out_ready  out_byte[7:0], frame_end, frame_kind[2:0]
// config   cfg_valid / cfg_ready  video_channel[7:0]
//
// One input word per cycle while the four-entry command queue has room.
// A word that opens a NAL unit costs a four-byte start code on the output
// plus the byte itself, so output bandwidth through the back end sets the sustained rate.
// Reset clears parser, queue and output valid flag; video channel resets to 2.
// Output stalls fill the queue, then in_ready drops; cfg_ready is always high.
module rtp_h264_interleaved_depacketizer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] data_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       frame_end,
	output logic [2:0] frame_kind,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] video_channel
);

	logic [7:0]      video_channel_q;
	logic            push;
	logic            pop;
	logic            q_full;
	logic            q_empty;
	rhid_pkg::cmd_t  push_cmd;
	rhid_pkg::cmd_t  head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			video_channel_q <= rhid_pkg::VIDEO_CHAN_RST;
		else if (cfg_valid && cfg_ready)
			video_channel_q <= video_channel;
	end

	rhid_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.data_byte     (data_byte),
		.video_channel (video_channel_q),
		.q_full        (q_full),
		.push          (push),
		.push_cmd      (push_cmd)
	);

	rhid_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.full     (q_full),
		.empty    (q_empty),
		.head     (head)
	);

	rhid_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.empty      (q_empty),
		.head       (head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.frame_end  (frame_end),
		.frame_kind (frame_kind)
	);

endmodule
